// File: hw/rtl/hsfc_pkg.sv
// Package for the half/single float converter: function codes and the two
// combinational conversion functions. No dependencies.
package hsfc_pkg;

  typedef enum logic {
    FUNC_S2H = 1'b0,
    FUNC_H2S = 1'b1
  } func_e;

  localparam logic [30:0] S2H_OVF_LIM  = 31'h477ff000;
  localparam logic [30:0] S2H_ZERO_LIM = 31'h33000000;
  localparam logic [30:0] S2H_NORM_MIN = 31'h38800000;
  localparam logic [30:0] S2H_INF      = 31'h7f800000;
  localparam logic [30:0] S2H_EBIAS    = 31'h38000000;

  // Narrow a single pattern to half with round to nearest even.
  function automatic logic [15:0] single_to_half(input logic [31:0] x);
    logic [30:0] a;
    logic [7:0]  e;
    logic [4:0]  sh;
    logic [23:0] m;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] hlf;
    logic [30:0] r;
    logic [17:0] qn;
    logic [14:0] h;
    a   = x[30:0];
    e   = a[30:23];
    sh  = 5'(8'd126 - e);
    m   = {1'b1, a[22:0]};
    q   = m >> sh;
    rem = m & ((24'd1 << sh) - 24'd1);
    hlf = 24'd1 << (sh - 5'd1);
    r   = a - S2H_EBIAS;
    qn  = r[30:13];
    if (a >= S2H_OVF_LIM) begin
      if (a > S2H_INF) h = {5'h1f, 1'b1, a[21:13]};
      else h = 15'h7c00;
    end else if (a <= S2H_ZERO_LIM) begin
      h = '0;
    end else if (a < S2H_NORM_MIN) begin
      if (rem > hlf || (rem == hlf && q[0])) q = q + 24'd1;
      h = q[14:0];
    end else begin
      if (r[12:0] > 13'h1000 || (r[12:0] == 13'h1000 && qn[0])) qn = qn + 18'd1;
      h = qn[14:0];
    end
    return {x[31], h};
  endfunction

  // Widen a half pattern to single; exact.
  function automatic logic [31:0] half_to_single(input logic [15:0] hv);
    logic [14:0] x;
    logic [3:0]  p;
    logic [30:0] r;
    x = hv[14:0];
    p = '0;
    for (int i = 0; i < 10; i++) begin
      if (x[i]) p = 4'(i);
    end
    if (x[14:10] == 5'd0) begin
      if (x == '0) r = '0;
      else r = {8'(p) + 8'd103, 23'(({8'd0, x} << (5'd23 - 5'(p))))};
    end else if (x[14:10] == 5'h1f) begin
      r = {8'hff, x[9] | (x[8:0] != '0), x[8:0], 13'd0};
    end else begin
      r = {3'(x[14:10]) == 3'd0 ? 8'(x[14:10]) + 8'd112 : 8'(x[14:10]) + 8'd112,
           x[9:0], 13'd0};
    end
    return {hv[15], r};
  endfunction

endpackage

// File: hw/rtl/hsfc_datapath.sv
// Combinational conversion between input register and result register.
// Depends on hsfc_pkg.
module hsfc_datapath (
  input  logic [0:0]  func_i,
  input  logic [31:0] operand_i,
  output logic [31:0] result_o
);

  // Select the direction of conversion.
  always_comb begin
    unique case (hsfc_pkg::func_e'(func_i))
      hsfc_pkg::FUNC_S2H: result_o = {16'd0, hsfc_pkg::single_to_half(operand_i)};
      hsfc_pkg::FUNC_H2S: result_o = hsfc_pkg::half_to_single(operand_i[15:0]);
      default:            result_o = '0;
    endcase
  end

endmodule

// File: hw/rtl/half_single_float_converter_core.sv
// Half/single float converter. Accepts one word per clock cycle unless
// in_stall_o is high; each word passes an input register and the conversion
// logic and is shown in the result register, which drives out_valid_o.
// The input stage advances whenever it is empty or the result register is empty or taken.
// Depends on hsfc_pkg and hsfc_datapath.
module half_single_float_converter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  func_i,
  input  logic [31:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_o
);

  logic        s1_valid_q;
  logic [0:0]  func_q;
  logic [31:0] operand_q;
  logic        out_valid_q;
  logic [31:0] result_q;
  logic [31:0] result_d;
  logic        out_adv;
  logic        s1_adv;

  // Pipeline moves when downstream stage can take the word.
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;

  hsfc_datapath u_dp (
    .func_i   (func_q),
    .operand_i(operand_q),
    .result_o (result_d)
  );

  // Control valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (out_adv) out_valid_q <= s1_valid_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      func_q    <= func_i;
      operand_q <= operand_i;
    end
    if (out_adv && s1_valid_q) result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// File: hw/rtl/hsfc_checker.sv
// Port-level checker for the converter, bound to the top level.
// Depends on half_single_float_converter_core.
module hsfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_o
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o))
    else $error("result changed under stall");

  // Input is never stalled while output is free.
  a_nostall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // An accepted word, taken while the output is free, passes the input register and then shows out_valid_o.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("accepted word not delivered");

endmodule

bind half_single_float_converter_core hsfc_checker u_hsfc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .result_o(result_o)
);
